FILE: design/mcbq_pkg.sv
package mcbq_pkg;

  localparam int unsigned SLOTS = 6;
  localparam int unsigned COEF_SHIFT = 20;

  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;
  localparam logic [2:0] SLOT_GAIN = 3'd5;

  localparam logic CMD_COEF = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic               command;
    logic [4:0]         channel;
    logic signed [15:0] sample;
    logic [4:0]         coef_index;
    logic signed [23:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         out_channel;
    logic signed [15:0] filtered_sample;
  } out_item_t;

  // h0 is the newest word, h1 the one before
  typedef struct packed {
    logic signed [31:0] h0;
    logic signed [31:0] h1;
  } hist_t;

  typedef struct packed {
    logic       we;
    logic [7:0] idx;
    logic signed [23:0] value;
  } coef_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RUN,
    ST_HOLD
  } ctrl_state_e;

  // floor(v / 2^20), saturated to signed 32 bits
  function automatic logic signed [31:0] sat_q20(input logic signed [63:0] v);
    logic signed [43:0] s;
    s = v[63:20];
    if (s > 44'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (s < -44'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return s[31:0];
    end
  endfunction

endpackage

FILE: design/mcbq_hist_mem.sv
module mcbq_hist_mem
  import mcbq_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output hist_t         rdata_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  hist_t         wdata_i
);

  hist_t            mem_q [DEPTH];
  hist_t            rdata_q;
  logic [DEPTH-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // entries not yet written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/mcbq_section_cell.sv
module mcbq_section_cell
  import mcbq_pkg::*;
#(
  parameter int unsigned SECTION = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  coef_wr_t           coef_wr_i,
  input  logic               start_i,
  input  logic signed [31:0] x_i,
  input  hist_t              xh_i,
  input  hist_t              yh_i,
  output logic               done_o,
  output logic signed [31:0] y_o
);

  localparam logic [7:0] BASE = 8'(SECTION * SLOTS);
  localparam logic [7:0] LAST = 8'(SECTION * SLOTS + SLOTS);

  logic signed [23:0] coef_q [SLOTS];
  logic               busy_q;
  logic [3:0]         step_q;
  logic signed [31:0] x_q, t_q, y_q;
  logic signed [55:0] p_q;
  logic signed [63:0] acc_q;
  logic               done_q;
  logic signed [23:0] mul_a;
  logic signed [31:0] mul_b;
  logic [7:0]         slot;

  assign slot = coef_wr_i.idx - BASE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (coef_wr_i.we && coef_wr_i.idx >= BASE && coef_wr_i.idx < LAST) begin
      coef_q[slot[2:0]] <= coef_wr_i.value;
    end
  end

  always_comb begin
    case (step_q)
      4'd0: begin mul_a = coef_q[SLOT_B0]; mul_b = x_q; end
      4'd1: begin mul_a = coef_q[SLOT_B1]; mul_b = xh_i.h0; end
      4'd2: begin mul_a = coef_q[SLOT_B2]; mul_b = xh_i.h1; end
      4'd5: begin mul_a = coef_q[SLOT_GAIN]; mul_b = t_q; end
      4'd6: begin mul_a = coef_q[SLOT_A1]; mul_b = yh_i.h0; end
      4'd7: begin mul_a = coef_q[SLOT_A2]; mul_b = yh_i.h1; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= 56'(mul_a) * 56'(mul_b);
    if (start_i) begin
      x_q <= x_i;
    end
    case (step_q)
      4'd1, 4'd6: acc_q <= 64'(p_q);
      4'd2, 4'd3: acc_q <= acc_q + 64'(p_q);
      4'd7, 4'd8: acc_q <= acc_q - 64'(p_q);
      4'd4: t_q <= sat_q20(acc_q);
      4'd9: y_q <= sat_q20(acc_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == 4'd9) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + 4'd1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign y_o = y_q;

endmodule

FILE: design/multichannel_cascaded_biquad_iir_unit.sv
// Per-channel cascade of up to MAX_SECTIONS direct-form-1 biquads. The number of
// active sections comes from the cfg port and is clamped to 1..MAX_SECTIONS. Each
// section cell runs its six products through its own multiplier one at a time and
// hands its output to the next cell. A coefficient item is written into the section
// cells when it is accepted. Histories live in one memory per section boundary
// (MAX_SECTIONS+1 in all), read once per sample. One item is worked on at a time;
// a finished result waits in the output register while the next item is taken.
module multichannel_cascaded_biquad_iir_unit
  import mcbq_pkg::*;
#(
  parameter int unsigned CHANNELS = 32,
  parameter int unsigned MAX_SECTIONS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [2:0] cfg_data_i
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  ctrl_state_e state_q, state_d;
  logic [2:0]  nsec_q;
  logic [4:0]  n_eff;
  logic [4:0]  ch_q;
  logic signed [31:0] x0_q;
  logic signed [31:0] res_q;
  logic signed [31:0] y_last;
  logic        out_valid_q;
  out_item_t   out_q;
  logic        accept, smp_ok, final_done, start0, load_out;
  logic [8:0]  ch_ext;
  logic [8:0]  chq_ext;

  logic               start [MAX_SECTIONS];
  logic               done  [MAX_SECTIONS];
  logic signed [31:0] y     [MAX_SECTIONS];
  logic signed [31:0] xin   [MAX_SECTIONS+1];
  hist_t              rd    [MAX_SECTIONS+1];
  logic               we    [MAX_SECTIONS+1];
  logic [MAX_SECTIONS-1:0] fin_vec;
  coef_wr_t           coef_wr;
  logic signed [31:0] rnd;
  logic signed [23:0] q;
  logic signed [15:0] q16;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept = in_valid_i && !in_stall_o;
  assign ch_ext = 9'(in_item_i.channel);
  assign chq_ext = 9'(ch_q);
  assign smp_ok = accept && in_item_i.command == CMD_SAMPLE && ch_ext < 9'(CHANNELS);

  assign coef_wr = '{we:    accept && in_item_i.command == CMD_COEF,
                     idx:   8'(in_item_i.coef_index),
                     value: in_item_i.coef_value};

  always_comb begin
    if (nsec_q == 3'd0) begin
      n_eff = 5'd1;
    end else if (5'(nsec_q) > 5'(MAX_SECTIONS)) begin
      n_eff = 5'(MAX_SECTIONS);
    end else begin
      n_eff = 5'(nsec_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nsec_q <= 3'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      nsec_q <= cfg_data_i;
    end
  end

  always_comb begin
    y_last = y[0];
    for (int k = 1; k < MAX_SECTIONS; k++) begin
      if (n_eff == 5'(k + 1)) begin
        y_last = y[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_ok) begin
      ch_q <= in_item_i.channel;
      x0_q <= 32'(in_item_i.sample) <<< 8;
    end
    if (final_done) begin
      res_q <= y_last;
    end
  end

  assign start0 = (state_q == ST_READ);
  assign final_done = (state_q == ST_RUN) && (|fin_vec);
  assign load_out = (state_q == ST_HOLD) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (smp_ok) state_d = ST_READ;
      ST_READ: state_d = ST_RUN;
      ST_RUN:  if (final_done) state_d = ST_HOLD;
      ST_HOLD: if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign xin[0] = x0_q;

  for (genvar s = 0; s < MAX_SECTIONS; s++) begin : g_cell
    if (s == 0) begin : g_first
      assign start[s] = start0;
    end else begin : g_rest
      assign start[s] = done[s-1] && (5'(s) < n_eff);
    end
    assign fin_vec[s] = done[s] && (n_eff == 5'(s + 1));
    assign xin[s+1] = y[s];

    mcbq_section_cell #(
      .SECTION(s)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .coef_wr_i(coef_wr),
      .start_i  (start[s]),
      .x_i      (xin[s]),
      .xh_i     (rd[s]),
      .yh_i     (rd[s+1]),
      .done_o   (done[s]),
      .y_o      (y[s])
    );
  end

  for (genvar k = 0; k <= MAX_SECTIONS; k++) begin : g_hist
    hist_t wdata;
    if (k < MAX_SECTIONS) begin : g_sec
      assign we[k] = start[k] || (final_done && n_eff == 5'(k));
    end else begin : g_tail
      assign we[k] = final_done && n_eff == 5'(k);
    end
    assign wdata = '{h0: xin[k], h1: rd[k].h0};

    mcbq_hist_mem #(
      .DEPTH(CHANNELS),
      .AW   (AW)
    ) u_mem (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .re_i   (smp_ok),
      .raddr_i(ch_ext[AW-1:0]),
      .rdata_o(rd[k]),
      .we_i   (we[k]),
      .waddr_i(chq_ext[AW-1:0]),
      .wdata_i(wdata)
    );
  end

  // divide by 256 toward zero, then clip to 16 bits
  assign rnd = res_q[31] ? (res_q + 32'sd255) : res_q;
  assign q = rnd[31:8];
  always_comb begin
    if (q > 24'sd32767) begin
      q16 = 16'sh7FFF;
    end else if (q < -24'sd32768) begin
      q16 = 16'sh8000;
    end else begin
      q16 = q[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.out_channel <= ch_q;
      out_q.filtered_sample <= q16;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

endmodule

FILE: bench/multichannel_cascaded_biquad_iir_unit_tb.sv
module multichannel_cascaded_biquad_iir_unit_tb
  import mcbq_pkg::*;
();

  localparam int NCH = 32;
  localparam int NSEC = 4;
  localparam int NCOEF = SLOTS * NSEC;
  localparam int LIMIT = 3000000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [2:0] cfg_data_i = '0;

  multichannel_cascaded_biquad_iir_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // filter state mirror
  logic signed [23:0] coefs [NCOEF];
  logic signed [31:0] hist [NCH][NSEC+1][2];
  logic [2:0] sections;
  out_item_t filtered_q [$];
  int errors = 0;
  int n_results = 0;
  int n_samples = 0;
  int cycles = 0;
  bit quiet_run = 0;
  bit hold_rx = 0;

  function automatic logic signed [31:0] floor_sat(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = v >>> COEF_SHIFT;
    if (s > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  task automatic filter_item(input in_item_t it);
    int n;
    logic signed [31:0] x, y, t;
    logic signed [63:0] acc, q;
    out_item_t r;
    if (it.command == CMD_COEF) begin
      if (it.coef_index < NCOEF) coefs[it.coef_index] = it.coef_value;
      return;
    end
    n = sections;
    if (n < 1) n = 1;
    if (n > NSEC) n = NSEC;
    x = 32'(it.sample) <<< 8;
    for (int s = 0; s < n; s++) begin
      acc = 64'(coefs[s*SLOTS+SLOT_B0]) * 64'(x)
          + 64'(coefs[s*SLOTS+SLOT_B1]) * 64'(hist[it.channel][s][0])
          + 64'(coefs[s*SLOTS+SLOT_B2]) * 64'(hist[it.channel][s][1]);
      t = floor_sat(acc);
      acc = 64'(coefs[s*SLOTS+SLOT_GAIN]) * 64'(t)
          - 64'(coefs[s*SLOTS+SLOT_A1]) * 64'(hist[it.channel][s+1][0])
          - 64'(coefs[s*SLOTS+SLOT_A2]) * 64'(hist[it.channel][s+1][1]);
      y = floor_sat(acc);
      hist[it.channel][s][1] = hist[it.channel][s][0];
      hist[it.channel][s][0] = x;
      x = y;
    end
    hist[it.channel][n][1] = hist[it.channel][n][0];
    hist[it.channel][n][0] = x;
    q = (x >= 0) ? 64'(x) / 256 : -((-64'(x)) / 256);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    r.out_channel = it.channel;
    r.filtered_sample = q[15:0];
    filtered_q.push_back(r);
    n_samples++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver
  initial begin
    int k;
    out_item_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (filtered_q.size() == 0) begin
          $error("result with nothing expected: ch %0d val %0d",
                 out_item_o.out_channel, out_item_o.filtered_sample);
          errors++;
        end else begin
          e = filtered_q.pop_front();
          if (out_item_o.out_channel !== e.out_channel) begin
            $error("out_channel exp %0d got %0d", e.out_channel, out_item_o.out_channel);
            errors++;
          end
          if (out_item_o.filtered_sample !== e.filtered_sample) begin
            $error("filtered_sample exp %0d got %0d",
                   e.filtered_sample, out_item_o.filtered_sample);
            errors++;
          end
        end
        n_results++;
      end
      if (hold_rx) begin
        k = k + 1;
        out_stall_i <= (k < 400);
        if (k >= 400) hold_rx = 0;
      end else begin
        k = 0;
        out_stall_i <= quiet_run ? 1'b0 : ($urandom_range(99) < 28);
      end
    end
  end

  task automatic send(input in_item_t it);
    while (!quiet_run && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    filter_item(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_sections(input logic [2:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sections = v;
  endtask

  function automatic in_item_t coef_item(input int idx, input int val);
    in_item_t it;
    it = '0;
    it.command = CMD_COEF;
    it.coef_index = idx[4:0];
    it.coef_value = val[23:0];
    it.channel = 5'($urandom);
    it.sample = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t sample_item(input int ch, input int v);
    in_item_t it;
    it = '0;
    it.command = CMD_SAMPLE;
    it.channel = ch[4:0];
    it.sample = v[15:0];
    it.coef_index = 5'($urandom);
    it.coef_value = 24'($urandom);
    return it;
  endfunction

  // random stable-ish biquad; occasionally extreme words
  task automatic load_coefs(input int nsec);
    for (int s = 0; s < nsec; s++) begin
      send(coef_item(s*SLOTS+SLOT_B0, $urandom_range(0, 1 << 20)));
      send(coef_item(s*SLOTS+SLOT_B1, int'($urandom_range(0, 1 << 21)) - (1 << 20)));
      send(coef_item(s*SLOTS+SLOT_B2, int'($urandom_range(0, 1 << 20)) - (1 << 19)));
      send(coef_item(s*SLOTS+SLOT_A1, int'($urandom_range(0, 1 << 21)) - (1 << 20)));
      send(coef_item(s*SLOTS+SLOT_A2, int'($urandom_range(0, 900000)) - 450000));
      send(coef_item(s*SLOTS+SLOT_GAIN, ($urandom_range(99) < 10) ?
                     (($urandom & 1) ? 8388607 : -8388608) : $urandom_range(0, 2 << 20)));
    end
  endtask

  typedef struct {
    in_item_t it;
    bit       has_exp;
    out_item_t exp_r;
  } dir_row_t;

  dir_row_t rows [$];

  function automatic dir_row_t row(input in_item_t it, input bit h, input int ch, input int v);
    dir_row_t r;
    r.it = it;
    r.has_exp = h;
    r.exp_r.out_channel = ch[4:0];
    r.exp_r.filtered_sample = v[15:0];
    return r;
  endfunction

  initial begin
    in_item_t it;
    int done_items;
    for (int i = 0; i < NCOEF; i++) coefs[i] = '0;
    for (int c = 0; c < NCH; c++)
      for (int s = 0; s <= NSEC; s++) hist[c][s] = '{0, 0};
    sections = 3'd1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero table after reset: output is zero
    rows.push_back(row(sample_item(0, 32767), 1, 0, 0));
    rows.push_back(row(sample_item(31, -32768), 1, 31, 0));
    // identity section: b0 = 1.0, gain = 1.0
    rows.push_back(row(coef_item(SLOT_B0, 1 << 20), 0, 0, 0));
    rows.push_back(row(coef_item(SLOT_GAIN, 1 << 20), 0, 0, 0));
    rows.push_back(row(sample_item(5, 32767), 1, 5, 32767));
    rows.push_back(row(sample_item(5, -32768), 1, 5, -32768));
    rows.push_back(row(sample_item(6, -1), 1, 6, -1));
    // out-of-range index ignored
    rows.push_back(row(coef_item(31, 12345), 0, 0, 0));
    rows.push_back(row(coef_item(24, -8388608), 0, 0, 0));
    // saturating gain
    rows.push_back(row(coef_item(SLOT_GAIN, 8388607), 0, 0, 0));
    rows.push_back(row(sample_item(7, 32767), 1, 7, 32767));
    rows.push_back(row(sample_item(8, -32768), 1, 8, -32768));
    rows.push_back(row(coef_item(SLOT_GAIN, -8388608), 0, 0, 0));
    rows.push_back(row(sample_item(9, 32767), 1, 9, -32768));
    rows.push_back(row(coef_item(SLOT_A1, -8388608), 0, 0, 0));
    rows.push_back(row(coef_item(SLOT_B1, 8388607), 0, 0, 0));
    rows.push_back(row(sample_item(9, 100), 0, 0, 0));
    rows.push_back(row(sample_item(9, -100), 0, 0, 0));
    rows.push_back(row(sample_item(9, 0), 0, 0, 0));

    foreach (rows[i]) begin
      send(rows[i].it);
      if (rows[i].has_exp && filtered_q.size() != 0 &&
          filtered_q[$] != rows[i].exp_r) begin
        $error("table row %0d out_channel exp %0d got %0d, filtered_sample exp %0d got %0d",
               i, rows[i].exp_r.out_channel, filtered_q[$].out_channel,
               rows[i].exp_r.filtered_sample, filtered_q[$].filtered_sample);
        errors++;
      end
    end
    drain();

    // settings walk: zero and out-of-range counts clamp
    for (int ph = 0; ph < 10; ph++) begin
      logic [2:0] ns;
      case (ph)
        0: ns = 3'd0;
        1: ns = 3'd4;
        2: ns = 3'd7;
        3: ns = 3'd1;
        4: ns = 3'd5;
        default: ns = 3'($urandom_range(0, 7));
      endcase
      set_sections(ns);
      quiet_run = (ph == 3);
      if (ph == 2) hold_rx = 1;
      load_coefs(NSEC);
      done_items = 0;
      while (done_items < 180) begin
        if ($urandom_range(99) < 6) begin
          send(coef_item($urandom_range(0, 31),
                         ($urandom_range(99) < 30) ? $urandom : $urandom_range(0, 1 << 20)));
        end else begin
          it = sample_item($urandom_range(0, 3) == 0 ? $urandom_range(0, 31) :
                           $urandom_range(0, 3),
                           ($urandom_range(99) < 10) ? (($urandom & 1) ? 32767 : -32768) :
                           int'($urandom));
          send(it);
        end
        done_items++;
      end
      quiet_run = 0;
      drain();
    end

    if (filtered_q.size() != 0) begin
      $error("%0d filtered samples never came out", filtered_q.size());
      errors++;
    end
    $display("Covered %0d samples, %0d results, section counts 0..7, extremes and saturation.",
             n_samples, n_results);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
design/mcbq_pkg.sv
design/mcbq_hist_mem.sv
design/mcbq_section_cell.sv
design/multichannel_cascaded_biquad_iir_unit.sv
bench/multichannel_cascaded_biquad_iir_unit_tb.sv
